/* hdl/planar_rigid_transform_assert.svh */
// ----------------------------------------------------------------------------
// planar rigid transform assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PLANAR_RIGID_TRANSFORM_ASSERT_SVH
`define PLANAR_RIGID_TRANSFORM_ASSERT_SVH

// same-cycle implication
`define PRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/prt_pkg.sv */
// ----------------------------------------------------------------------------
// prt_pkg
// Constants, codes and types of the planar rigid transform block.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 16;

    localparam int ANG_W        = 15;
    localparam int DATA_W       = 32;
    localparam int OP_W         = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int ANG_FRAC     = 12;
    localparam int ANG_Q        = 30;
    localparam int ANG_SCALE_SH = ANG_Q - ANG_FRAC;
    localparam int Z_W          = ANG_W + ANG_SCALE_SH + 1;
    localparam int C_W          = 32;
    localparam int PROD_W       = 64;
    localparam int SUM_W        = PROD_W + 2;
    localparam int RQ_W         = SUM_W - ANG_Q;

    localparam logic signed [Z_W-1:0] PI_Q30       = 34'sd3373259426;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30  = 34'sd1686629713;
    localparam logic signed [Z_W-1:0] NHALF_PI_Q30 = -34'sd1686629713;
    localparam logic signed [C_W-1:0] KINV_Q30     = 32'sd652032874;

    localparam logic signed [C_W-1:0] ATAN_Q30 [32] = '{
        32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
        32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
        32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
        32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
        32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
        32'sd1024,      32'sd512,       32'sd256,       32'sd128,
        32'sd64,        32'sd32,        32'sd16,        32'sd8,
        32'sd4,         32'sd2,         32'sd1,         32'sd1
    };

    // bound on the angle left over after the last micro-rotation
    localparam logic signed [Z_W-1:0] Z_RESID_MAX =
        Z_W'(2 * ATAN_Q30[CORDIC_STAGES-1] + CORDIC_STAGES);

    // angle (Q3.12) to output fraction conversion
    localparam int ANG_SH_L = (FRAC_BITS >= ANG_FRAC) ? FRAC_BITS - ANG_FRAC : 0;
    localparam int ANG_SH_R = (FRAC_BITS <  ANG_FRAC) ? ANG_FRAC - FRAC_BITS : 0;
    localparam logic signed [DATA_W-1:0] ANG_RND = DATA_W'((1 << ANG_SH_R) >> 1);

    localparam longint FRAC_RND_I = (longint'(1) << FRAC_BITS) >> 1;
    localparam longint Q30_RND_I  = longint'(1) << (ANG_Q - 1);
    localparam longint OUT_MAX_I  = (longint'(1) << (DATA_W - 1)) - 1;
    localparam longint OUT_MIN_I  = -(longint'(1) << (DATA_W - 1));

    typedef enum logic [OP_W-1:0] {
        OP_POINT   = 2'd0,
        OP_TWIST   = 2'd1,
        OP_INVERSE = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_ANGLE = 2'd0,
        REG_OFFSET_X  = 2'd1,
        REG_OFFSET_Y  = 2'd2
    } cfg_reg_t;

    // what an item carries alongside the rotation pipeline
    typedef struct packed {
        opcode_t                   op;
        logic signed [DATA_W-1:0]  a;
        logic signed [DATA_W-1:0]  b;
        logic signed [DATA_W-1:0]  ox;
        logic signed [DATA_W-1:0]  oy;
        logic signed [DATA_W-1:0]  w;
        logic signed [DATA_W-1:0]  wout;
    } item_t;

endpackage

/* hdl/planar_rigid_transform.sv */
// ----------------------------------------------------------------------------
// planar_rigid_transform
// SE(2) point map, twist adjoint and inverse report with a pipelined CORDIC.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled and returns one
// result per item, in order. The pipe holds an entry stage that folds the
// configured angle into the CORDIC range, one pipeline stage per CORDIC
// micro-rotation, a multiply stage, a rounding stage and the output register.
// Each item carries its own copy of the angle and offsets through the pipe,
// so a configuration write affects only items accepted after it. A stalled
// output holds; bubbles inside the pipe still close up, so the input keeps
// taking items until every stage is full.
`include "planar_rigid_transform_assert.svh"

module planar_rigid_transform
    import prt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OP_W-1:0]          opcode,
    input  logic signed [DATA_W-1:0] in_x,
    input  logic signed [DATA_W-1:0] in_y,
    input  logic signed [DATA_W-1:0] in_rate,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] out_x,
    output logic signed [DATA_W-1:0] out_y,
    output logic signed [DATA_W-1:0] out_w,
    output logic                     saturated
);

    localparam int MUL_S = CORDIC_STAGES + 1;
    localparam int SUM_S = CORDIC_STAGES + 2;
    localparam int OUT_S = CORDIC_STAGES + 3;
    localparam int NS    = CORDIC_STAGES + 4;

    // configuration
    logic signed [ANG_W-1:0]  rot_angle_reg;
    logic signed [DATA_W-1:0] offset_x_reg;
    logic signed [DATA_W-1:0] offset_y_reg;

    // pipeline control
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;

    // cordic pipe, index 0 is the entry stage
    logic signed [C_W-1:0] cx_reg   [CORDIC_STAGES+1];
    logic signed [C_W-1:0] cy_reg   [CORDIC_STAGES+1];
    logic signed [Z_W-1:0] cz_reg   [CORDIC_STAGES+1];
    logic                  cneg_reg [CORDIC_STAGES+1];
    item_t                 citem_reg[CORDIC_STAGES+1];

    // entry stage
    logic signed [Z_W-1:0]    z_raw;
    logic signed [Z_W-1:0]    z0_next;
    logic                     neg0_next;
    logic signed [ANG_W:0]    ang_neg;
    logic signed [DATA_W-1:0] ang_ext;
    logic signed [DATA_W-1:0] ang_frac;
    item_t                    item0_next;

    // multiply stage
    logic signed [PROD_W-1:0] pa_reg, pb_reg, pc_reg, pd_reg, pe_reg, pf_reg;
    logic signed [PROD_W-1:0] pa_next, pb_next, pc_next, pd_next, pe_next, pf_next;
    logic                     mneg_reg;
    item_t                    mitem_reg;

    // rounding stage
    logic signed [SUM_W-1:0] ea, eb, ec, ed, te, tf;
    logic signed [SUM_W-1:0] rx_sum, ry_sum;
    logic                    rxa_neg, rxb_neg, rya_neg, ryb_neg;
    logic signed [RQ_W-1:0]  rxr_reg, ryr_reg, rxr_next, ryr_next;
    logic signed [SUM_W-1:0] tx_reg, ty_reg, tx_next, ty_next;
    item_t                   sitem_reg;

    // output stage
    logic signed [SUM_W-1:0]  fx, fy;
    logic signed [DATA_W-1:0] out_x_reg, out_y_reg, out_w_reg;
    logic signed [DATA_W-1:0] out_x_next, out_y_next, out_w_next;
    logic                     sat_reg, sat_next;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_angle_reg <= '0;
            offset_x_reg  <= '0;
            offset_y_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROT_ANGLE: rot_angle_reg <= cfg_data[ANG_W-1:0];
                REG_OFFSET_X:  offset_x_reg  <= cfg_data;
                REG_OFFSET_Y:  offset_y_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage enables: a stage loads when empty or when its successor loads
    // ------------------------------------------------------------------
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int s = NS - 2; s >= 0; s--)
        begin
            en[s] = !v_reg[s] || en[s+1];
        end
        if (en[0])
            v_next[0] = in_valid;
        else
            v_next[0] = v_reg[0];
        for (int s = 1; s < NS; s++)
        begin
            if (en[s])
                v_next[s] = v_reg[s-1];
            else
                v_next[s] = v_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_ready = en[0];

    // ------------------------------------------------------------------
    // entry: quadrant fold, operand select, angle for out_w
    // ------------------------------------------------------------------
    always_comb
    begin
        z_raw = {rot_angle_reg[ANG_W-1], rot_angle_reg, {ANG_SCALE_SH{1'b0}}};
        if (z_raw > HALF_PI_Q30)
        begin
            z0_next   = z_raw - PI_Q30;
            neg0_next = 1'b1;
        end
        else if (z_raw < NHALF_PI_Q30)
        begin
            z0_next   = z_raw + PI_Q30;
            neg0_next = 1'b1;
        end
        else
        begin
            z0_next   = z_raw;
            neg0_next = 1'b0;
        end

        ang_neg  = -(ANG_W+1)'(rot_angle_reg);
        ang_ext  = DATA_W'(ang_neg);
        ang_frac = ((ang_ext <<< ANG_SH_L) + ANG_RND) >>> ANG_SH_R;

        item0_next.op   = opcode_t'(opcode);
        item0_next.ox   = offset_x_reg;
        item0_next.oy   = offset_y_reg;
        item0_next.w    = in_rate;
        item0_next.a    = in_x;
        item0_next.b    = in_y;
        item0_next.wout = '0;
        unique case (opcode_t'(opcode))
            OP_TWIST:
                item0_next.wout = in_rate;
            OP_INVERSE:
            begin
                item0_next.a    = offset_x_reg;
                item0_next.b    = offset_y_reg;
                item0_next.wout = ang_frac;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            cx_reg[0]    <= KINV_Q30;
            cy_reg[0]    <= '0;
            cz_reg[0]    <= z0_next;
            cneg_reg[0]  <= neg0_next;
            citem_reg[0] <= item0_next;
        end
    end

    // ------------------------------------------------------------------
    // one cordic micro-rotation per stage
    // ------------------------------------------------------------------
    for (genvar j = 0; j < CORDIC_STAGES; j++)
    begin : g_cordic
        logic signed [C_W-1:0] dx, dy, x_next, y_next;
        logic signed [Z_W-1:0] z_next;

        always_comb
        begin
            dx = cy_reg[j] >>> j;
            dy = cx_reg[j] >>> j;
            if (cz_reg[j] >= 0)
            begin
                x_next = cx_reg[j] - dx;
                y_next = cy_reg[j] + dy;
                z_next = cz_reg[j] - Z_W'(ATAN_Q30[j]);
            end
            else
            begin
                x_next = cx_reg[j] + dx;
                y_next = cy_reg[j] - dy;
                z_next = cz_reg[j] + Z_W'(ATAN_Q30[j]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[j+1])
            begin
                cx_reg[j+1]    <= x_next;
                cy_reg[j+1]    <= y_next;
                cz_reg[j+1]    <= z_next;
                cneg_reg[j+1]  <= cneg_reg[j];
                citem_reg[j+1] <= citem_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // multiply: rotation products and twist offset products
    // ------------------------------------------------------------------
    always_comb
    begin
        pa_next = PROD_W'(cx_reg[CORDIC_STAGES]) * PROD_W'(citem_reg[CORDIC_STAGES].a);
        pb_next = PROD_W'(cy_reg[CORDIC_STAGES]) * PROD_W'(citem_reg[CORDIC_STAGES].b);
        pc_next = PROD_W'(cy_reg[CORDIC_STAGES]) * PROD_W'(citem_reg[CORDIC_STAGES].a);
        pd_next = PROD_W'(cx_reg[CORDIC_STAGES]) * PROD_W'(citem_reg[CORDIC_STAGES].b);
        pe_next = PROD_W'(citem_reg[CORDIC_STAGES].oy) * PROD_W'(citem_reg[CORDIC_STAGES].w);
        pf_next = PROD_W'(citem_reg[CORDIC_STAGES].ox) * PROD_W'(citem_reg[CORDIC_STAGES].w);
    end

    always_ff @(posedge clk)
    begin
        if (en[MUL_S])
        begin
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            pc_reg    <= pc_next;
            pd_reg    <= pd_next;
            pe_reg    <= pe_next;
            pf_reg    <= pf_next;
            mneg_reg  <= cneg_reg[CORDIC_STAGES];
            mitem_reg <= citem_reg[CORDIC_STAGES];
        end
    end

    // ------------------------------------------------------------------
    // rounding: signed sums back to the data fraction
    // ------------------------------------------------------------------
    always_comb
    begin
        ea = SUM_W'(pa_reg);
        eb = SUM_W'(pb_reg);
        ec = SUM_W'(pc_reg);
        ed = SUM_W'(pd_reg);

        // a folded angle negates cos and sin, so it flips every term
        rxa_neg = mneg_reg ^ (mitem_reg.op == OP_INVERSE);
        rxb_neg = !mneg_reg;
        rya_neg = mneg_reg;
        ryb_neg = mneg_reg ^ (mitem_reg.op == OP_INVERSE);

        rx_sum = (rxa_neg ? -ea : ea) + (rxb_neg ? -eb : eb) + SUM_W'(Q30_RND_I);
        ry_sum = (rya_neg ? -ec : ec) + (ryb_neg ? -ed : ed) + SUM_W'(Q30_RND_I);
        rxr_next = rx_sum[SUM_W-1:ANG_Q];
        ryr_next = ry_sum[SUM_W-1:ANG_Q];

        te = SUM_W'(pe_reg) + SUM_W'(FRAC_RND_I);
        tf = -SUM_W'(pf_reg) + SUM_W'(FRAC_RND_I);

        unique case (mitem_reg.op)
            OP_POINT:
            begin
                tx_next = SUM_W'(mitem_reg.ox);
                ty_next = SUM_W'(mitem_reg.oy);
            end
            OP_TWIST:
            begin
                tx_next = te >>> FRAC_BITS;
                ty_next = tf >>> FRAC_BITS;
            end
            default:
            begin
                tx_next = '0;
                ty_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[SUM_S])
        begin
            rxr_reg   <= rxr_next;
            ryr_reg   <= ryr_next;
            tx_reg    <= tx_next;
            ty_reg    <= ty_next;
            sitem_reg <= mitem_reg;
        end
    end

    // ------------------------------------------------------------------
    // final add and clamp into the output register
    // ------------------------------------------------------------------
    always_comb
    begin
        fx       = SUM_W'(rxr_reg) + tx_reg;
        fy       = SUM_W'(ryr_reg) + ty_reg;
        sat_next = 1'b0;

        if (fx > SUM_W'(OUT_MAX_I))
        begin
            out_x_next = DATA_W'(OUT_MAX_I);
            sat_next   = 1'b1;
        end
        else if (fx < SUM_W'(OUT_MIN_I))
        begin
            out_x_next = DATA_W'(OUT_MIN_I);
            sat_next   = 1'b1;
        end
        else
            out_x_next = fx[DATA_W-1:0];

        if (fy > SUM_W'(OUT_MAX_I))
        begin
            out_y_next = DATA_W'(OUT_MAX_I);
            sat_next   = 1'b1;
        end
        else if (fy < SUM_W'(OUT_MIN_I))
        begin
            out_y_next = DATA_W'(OUT_MIN_I);
            sat_next   = 1'b1;
        end
        else
            out_y_next = fy[DATA_W-1:0];

        out_w_next = sitem_reg.wout;

        // unused opcode gives an all-zero result
        if (sitem_reg.op == OP_NONE)
        begin
            out_x_next = '0;
            out_y_next = '0;
            out_w_next = '0;
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[OUT_S])
        begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
            out_w_reg <= out_w_next;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid = v_reg[OUT_S];
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_w     = out_w_reg;
    assign saturated = sat_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `PRT_ASSERT_NOW(a_cordic_converged,
        v_reg[CORDIC_STAGES],
        (cz_reg[CORDIC_STAGES] <= Z_RESID_MAX) && (cz_reg[CORDIC_STAGES] >= -Z_RESID_MAX),
        "cordic residual angle out of range")

    `PRT_ASSERT_NEXT(a_unused_op_zero,
        v_reg[SUM_S] && en[OUT_S] && (sitem_reg.op == OP_NONE),
        (out_x == '0) && (out_y == '0) && (out_w == '0) && !saturated,
        "unused opcode gave a nonzero result")

    `PRT_ASSERT_NOW(a_sat_means_clamped,
        out_valid && saturated,
        (out_x == DATA_W'(OUT_MAX_I)) || (out_x == DATA_W'(OUT_MIN_I)) ||
        (out_y == DATA_W'(OUT_MAX_I)) || (out_y == DATA_W'(OUT_MIN_I)),
        "saturated flag without a clamped component")

    `PRT_ASSERT_NEXT(a_stall_keeps_valid,
        out_valid && !out_ready,
        out_valid && $stable(out_x) && $stable(out_y) && $stable(out_w) && $stable(saturated),
        "output stage lost an item during a stall")

endmodule
